FILE: src/filter_handler_lookup_table_unit_macros.svh
// Assertion macros for the filter handler lookup table unit.
// Depends on clk_i and rst_ni being present in the module that asserts.
`ifndef FILTER_HANDLER_LOOKUP_TABLE_UNIT_MACROS_SVH
`define FILTER_HANDLER_LOOKUP_TABLE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FHLUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define FHLUT_ASSERT_IMP(lbl, ante, cons, msg) \
  `FHLUT_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define FHLUT_ASSERT_NXT(lbl, ante, cons, msg) \
  `FHLUT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: src/fhlut_pkg.sv
// Package for the filter handler lookup table unit.
// Holds table sizing, request and status codes and the entry layout; no dependencies.
package fhlut_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned ID_W          = 8;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned ENTRY_W       = 3 * ID_W;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEL    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0] hnd;
    logic [ID_W-1:0] filt;
    logic [ID_W-1:0] chan;
  } entry_t;

endpackage

FILE: src/fhlut_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the key and handler store of the lookup table.
module fhlut_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/filter_handler_lookup_table_unit.sv
// Filter handler lookup table: maps (channel, filter) keys to handler numbers.
// Each request scans every entry through the RAM read port, then S_DRAIN and S_DONE;
// S_DONE waits for a free output register; new requests are taken only in S_IDLE.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) clears all valid bits at once; no clearing pass.
// Depends on fhlut_pkg, fhlut_ram and the unit's assertion macros.
`include "filter_handler_lookup_table_unit_macros.svh"

module filter_handler_lookup_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] channel_id, [15:8] filter_id, [23:16] handler_id
  input  logic [fhlut_pkg::ENTRY_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [fhlut_pkg::REQ_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] handler_out
  output logic [fhlut_pkg::ID_W-1:0]    m_axis_tdata,
  // [0] found, [2:1] status
  output logic [2:0]                    m_axis_tuser
);

  import fhlut_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [REQ_W-1:0]   req_q;
  logic [ID_W-1:0]    chan_q;
  logic [ID_W-1:0]    filt_q;
  logic [ID_W-1:0]    hnd_q;
  logic [IDX_W-1:0]   idx_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [ID_W-1:0]    hit_hnd_q;
  logic               free_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic               out_vld_q;
  logic [ID_W-1:0]    out_hnd_q;
  logic               out_found_q;
  status_e            out_status_q;

  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               ram_we;
  logic               key_match;
  logic               is_free;
  logic               out_free;
  logic               done_go;
  logic               res_found;
  logic [ID_W-1:0]    res_hnd;
  status_e            res_status;

  assign rd_entry  = entry_t'(ram_rdata);
  assign wr_entry  = '{hnd: hnd_q, filt: filt_q, chan: chan_q};
  assign key_match = cmp_vld_q && valid_q[cmp_idx_q]
                     && (rd_entry.chan == chan_q) && (rd_entry.filt == filt_q);
  assign is_free   = cmp_vld_q && !valid_q[cmp_idx_q];
  assign out_free  = !out_vld_q || m_axis_tready;
  assign done_go   = (state_q == S_DONE) && out_free;
  assign ram_we    = done_go && (req_q == REQ_ADD) && !hit_q && free_q;

  fhlut_ram #(
    .Width(ENTRY_W),
    .Depth(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(wr_entry),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    res_found  = 1'b0;
    res_hnd    = '0;
    res_status = ST_OK;
    case (req_q)
      REQ_ADD: begin
        res_found  = hit_q;
        res_status = hit_q ? ST_DUP : (free_q ? ST_OK : ST_FULL);
      end
      REQ_DEL: begin
        res_found  = hit_q;
        res_status = hit_q ? ST_OK : ST_MISS;
      end
      REQ_LOOKUP: begin
        res_found = hit_q;
        res_hnd   = hit_q ? hit_hnd_q : '0;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      valid_q      <= '0;
      out_vld_q    <= 1'b0;
      out_found_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      cmp_vld_q <= 1'b0;
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (key_match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
        hit_hnd_q <= rd_entry.hnd;
      end
      if (is_free && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q   <= s_axis_tuser;
            chan_q  <= s_axis_tdata[ID_W-1:0];
            filt_q  <= s_axis_tdata[2*ID_W-1:ID_W];
            hnd_q   <= s_axis_tdata[3*ID_W-1:2*ID_W];
            idx_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_q <= 1'b1;
          cmp_idx_q <= idx_q;
          if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_found_q  <= res_found;
            out_hnd_q    <= res_hnd;
            out_status_q <= res_status;
            state_q      <= S_IDLE;
            if (ram_we) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            if ((req_q == REQ_DEL) && hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_hnd_q;
  assign m_axis_tuser  = {out_status_q, out_found_q};

  `FHLUT_ASSERT_NXT(a_add_sets_valid, ram_we, valid_q[$past(free_idx_q)], "add left entry invalid")
  `FHLUT_ASSERT_IMP(a_hit_is_valid, (state_q == S_DONE) && hit_q, valid_q[hit_idx_q], "hit on invalid entry")
  `FHLUT_ASSERT_IMP(a_hnd_needs_found, m_axis_tvalid && (m_axis_tdata != '0), m_axis_tuser[0], "handler without match")
  `FHLUT_ASSERT_IMP(a_found_status, m_axis_tvalid && m_axis_tuser[0], (m_axis_tuser[2:1] != ST_FULL) && (m_axis_tuser[2:1] != ST_MISS), "match with miss status")

endmodule

FILE: bench/filter_handler_lookup_table_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the filter handler lookup table unit: watches both stream channels,
// keeps its own copy of the key table and compares each answer in order.
// Depends on fhlut_pkg for sizes, request codes and status codes.
module filter_handler_lookup_table_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [7:0] channel_id, [15:8] filter_id, [23:16] handler_id
  input  logic [fhlut_pkg::ENTRY_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [fhlut_pkg::REQ_W-1:0]   s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] handler_out
  input  logic [fhlut_pkg::ID_W-1:0]    m_axis_tdata,
  // [0] found, [2:1] status
  input  logic [2:0]                    m_axis_tuser,
  output int                            mismatch_count_o,
  output int                            pending_o
);

  import fhlut_pkg::*;

  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] hnd;
    status_e         status;
  } answer_t;

  logic            key_valid [TABLE_ENTRIES];
  logic [ID_W-1:0] key_chan  [TABLE_ENTRIES];
  logic [ID_W-1:0] key_filt  [TABLE_ENTRIES];
  logic [ID_W-1:0] key_hnd   [TABLE_ENTRIES];
  answer_t         pending_answers [$];
  int              answer_idx;

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
    answer_idx = 0;
  end

  function automatic answer_t table_apply(logic [REQ_W-1:0] req, logic [ID_W-1:0] chan,
                                          logic [ID_W-1:0] filt, logic [ID_W-1:0] hnd);
    answer_t res;
    int      hit;
    int      free_slot;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (key_valid[i] && key_chan[i] == chan && key_filt[i] == filt && hit < 0) hit = i;
      if (!key_valid[i] && free_slot < 0) free_slot = i;
    end
    res.found = 1'b0;
    res.hnd = '0;
    res.status = ST_OK;
    case (req)
      REQ_ADD: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.status = ST_DUP;
        end else if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          key_valid[free_slot] = 1'b1;
          key_chan[free_slot] = chan;
          key_filt[free_slot] = filt;
          key_hnd[free_slot] = hnd;
        end
      end
      REQ_DEL: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          key_valid[hit] = 1'b0;
        end else begin
          res.status = ST_MISS;
        end
      end
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.hnd = key_hnd[hit];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got_val, int want_val);
    if (mismatch_count_o < PRINT_LIMIT)
      $display("[%0t] answer %0d: %s got %0d want %0d", $time, answer_idx, what, got_val,
               want_val);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      foreach (key_valid[i]) key_valid[i] = 1'b0;
      pending_answers.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_answers.push_back(table_apply(s_axis_tuser, s_axis_tdata[7:0],
                                              s_axis_tdata[15:8], s_axis_tdata[23:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser[0];
        got.status = status_e'(m_axis_tuser[2:1]);
        got.hnd = m_axis_tdata;
        if (pending_answers.size() == 0) begin
          report_mismatch("answer with no request pending, handler_out", got.hnd, -1);
        end else begin
          want = pending_answers.pop_front();
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.hnd !== want.hnd) report_mismatch("handler_out", got.hnd, want.hnd);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        end
        answer_idx++;
      end
    end
    pending_o = pending_answers.size();
  end

endmodule

FILE: bench/filter_handler_lookup_table_unit_test.sv
`timescale 1ns / 1ps
// Top of the lookup table bench: drives add, delete, lookup and unused requests with
// random gaps and output stalls, then gives the verdict from the checker's count.
// Depends on fhlut_pkg, filter_handler_lookup_table_unit and its checker.
module filter_handler_lookup_table_unit_test;
  import fhlut_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQS  = 1680;
  localparam int CALM_TAIL    = 200;
  localparam int POOL_SIZE    = 24;
  localparam int LONG_HOLD    = 150;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ENTRY_W-1:0] s_axis_tdata;
  logic [REQ_W-1:0]   s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [ID_W-1:0]    m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  int                 mismatches;
  int                 outstanding;
  int                 quiet_cycles = 0;
  bit                 idle_on;
  bit                 long_hold_req;
  logic [15:0]        key_pool [POOL_SIZE];

  filter_handler_lookup_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  filter_handler_lookup_table_unit_checker lookup_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] chan,
                          logic [ID_W-1:0] filt, logic [ID_W-1:0] hnd);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {hnd, filt, chan};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready = 1'b0;
        stall_left = LONG_HOLD - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("filter_handler_lookup_table_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    int               n;
    int               pick;
    logic [15:0]      key;
    logic [ID_W-1:0]  hnd;
    logic [REQ_W-1:0] req;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_on = 1'b0;
    long_hold_req = 1'b0;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_req(REQ_LOOKUP, 8'h00, 8'h00, 8'h5a);
    send_req(REQ_DEL, 8'hff, 8'hff, 8'h00);
    send_req(REQ_ADD, 8'h00, 8'h00, 8'h00);
    send_req(REQ_ADD, 8'hff, 8'hff, 8'hff);
    send_req(REQ_ADD, 8'h00, 8'h00, 8'haa);
    send_req(REQ_LOOKUP, 8'h00, 8'h00, 8'h00);
    send_req(REQ_LOOKUP, 8'hff, 8'hff, 8'h00);
    send_req(REQ_UNUSED, 8'hff, 8'hff, 8'hff);
    send_req(REQ_DEL, 8'hff, 8'hff, 8'h00);
    send_req(REQ_LOOKUP, 8'hff, 8'hff, 8'h00);
    for (n = 1; n < TABLE_ENTRIES; n++)
      send_req(REQ_ADD, n[7:0], ~n[7:0], 8'h80 | n[7:0]);
    send_req(REQ_ADD, 8'h12, 8'h34, 8'h56);
    send_req(REQ_LOOKUP, 8'h01, 8'h00, 8'h00);

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0)
        idle_on = (n < RANDOM_REQS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
      if (n % 250 == 249)
        repeat (6) key_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
      if (n == 600) long_hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) key = 16'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      hnd = 8'($urandom);
      if (pick < 40) req = REQ_ADD;
      else if (pick < 70) req = REQ_DEL;
      else if (pick < 95) req = REQ_LOOKUP;
      else req = REQ_UNUSED;
      send_req(req, key[7:0], key[15:8], hnd);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("filter_handler_lookup_table_unit_test: done, clean");
    end else begin
      $display("filter_handler_lookup_table_unit_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/fhlut_pkg.sv
src/fhlut_ram.sv
src/filter_handler_lookup_table_unit.sv
bench/filter_handler_lookup_table_unit_checker.sv
bench/filter_handler_lookup_table_unit_test.sv
